[rtl/step_detector_peak_qualifier_assert.svh]
// assertion macros shared by the step detector rtl
`ifndef STEP_DETECTOR_PEAK_QUALIFIER_ASSERT_SVH
`define STEP_DETECTOR_PEAK_QUALIFIER_ASSERT_SVH

`ifndef SYNTHESIS

// check with the property disabled while reset is high
`define SDPQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sdpq assertion failed");

// check that also runs during reset
`define SDPQ_CHECK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sdpq check failed");

`else

`define SDPQ_ASSERT(label, clk, rst, prop)
`define SDPQ_CHECK(label, clk, prop)

`endif

`endif

[rtl/sdpq_pkg.sv]
// shared types and constants of the step detector
`timescale 1ns / 1ps

package sdpq_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_PASS_ALPHA = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_ALPHA  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTER_THRESH   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXIT_THRESH    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PEAK_LEVEL = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PEAK_WIDTH = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PEAK_WIDTH = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP_GAP   = 4'd7;

  // register reset values
  localparam logic [15:0] RST_LOW_PASS_ALPHA = 16'd13107;
  localparam logic [15:0] RST_GRAVITY_ALPHA  = 16'd655;
  localparam logic [15:0] RST_ENTER_THRESH   = 16'd614;
  localparam logic [15:0] RST_EXIT_THRESH    = 16'd205;
  localparam logic [15:0] RST_MIN_PEAK_LEVEL = 16'd819;
  localparam logic [15:0] RST_MIN_PEAK_WIDTH = 16'd50;
  localparam logic [15:0] RST_MAX_PEAK_WIDTH = 16'd400;
  localparam logic [15:0] RST_MIN_STEP_GAP   = 16'd250;

  // sample format
  localparam int unsigned SAMPLE_FRAC_BITS = 12;

  // input queue depth between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // configuration register set
  typedef struct packed {
    logic [15:0] low_pass_alpha;
    logic [15:0] gravity_alpha;
    logic [15:0] enter_thresh;
    logic [15:0] exit_thresh;
    logic [15:0] min_peak_level;
    logic [15:0] min_peak_width;
    logic [15:0] max_peak_width;
    logic [15:0] min_step_gap;
  } cfg_t;

  // one queued sample, tagged by the front
  typedef struct packed {
    logic [15:0] accel_magnitude;
    logic [31:0] time_ms;
    logic        seed;
  } item_t;

endpackage

[rtl/step_detector_peak_qualifier.sv]
// top level: configuration registers, sample front end and step back end
//
// Usage:
//   Samples enter on in_valid / in_stall with accel_magnitude (unsigned Q4.12 g)
//   and time_ms. A transaction completes when in_valid is high and in_stall low.
//   Each sample yields exactly one result transaction on out_valid / out_stall
//   carrying step, in sample order.
//   Registers are written on cfg_valid / cfg_ready (cfg_ready is always high)
//   with cfg_index and cfg_data; indexes past the last register are ignored.
//   Write them only while no sample is in flight.
// Timing:
//   A two-entry queue sits between input and the filter sequencer. The
//   sequencer handles one sample at a time: two multiply / update passes
//   through one shared multiplier, then the peak decision; the seed sample
//   goes from loading the filters straight to the decision. The queue keeps
//   accepting samples into any free entry while the sequencer works.
// Reset:
//   rst is synchronous, active high; it empties the queue, restores register
//   defaults, sets filters to one, clears peak state; first sample seeds them.
// Backpressure:
//   While out_stall holds a result, the sequencer waits in its decision step
//   and the queue fills; in_stall rises once both queue entries are taken.
`timescale 1ns / 1ps

module step_detector_peak_qualifier #(
  parameter int unsigned FILTER_FRAC_BITS = 28
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [15:0]                        accel_magnitude,
  input  logic [31:0]                        time_ms,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               step,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sdpq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                        cfg_data
);

  sdpq_pkg::cfg_t   cfg;
  logic             q_valid;
  sdpq_pkg::item_t  q_item;
  logic             q_pop;

  assign cfg_ready = 1'b1;

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_pass_alpha <= sdpq_pkg::RST_LOW_PASS_ALPHA;
      cfg.gravity_alpha  <= sdpq_pkg::RST_GRAVITY_ALPHA;
      cfg.enter_thresh   <= sdpq_pkg::RST_ENTER_THRESH;
      cfg.exit_thresh    <= sdpq_pkg::RST_EXIT_THRESH;
      cfg.min_peak_level <= sdpq_pkg::RST_MIN_PEAK_LEVEL;
      cfg.min_peak_width <= sdpq_pkg::RST_MIN_PEAK_WIDTH;
      cfg.max_peak_width <= sdpq_pkg::RST_MAX_PEAK_WIDTH;
      cfg.min_step_gap   <= sdpq_pkg::RST_MIN_STEP_GAP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sdpq_pkg::REG_LOW_PASS_ALPHA: cfg.low_pass_alpha <= cfg_data;
        sdpq_pkg::REG_GRAVITY_ALPHA:  cfg.gravity_alpha  <= cfg_data;
        sdpq_pkg::REG_ENTER_THRESH:   cfg.enter_thresh   <= cfg_data;
        sdpq_pkg::REG_EXIT_THRESH:    cfg.exit_thresh    <= cfg_data;
        sdpq_pkg::REG_MIN_PEAK_LEVEL: cfg.min_peak_level <= cfg_data;
        sdpq_pkg::REG_MIN_PEAK_WIDTH: cfg.min_peak_width <= cfg_data;
        sdpq_pkg::REG_MAX_PEAK_WIDTH: cfg.max_peak_width <= cfg_data;
        sdpq_pkg::REG_MIN_STEP_GAP:   cfg.min_step_gap   <= cfg_data;
        default:                      cfg                <= cfg;
      endcase
    end
  end

  // sample acceptance and queue
  sdpq_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .accel_magnitude (accel_magnitude),
    .time_ms         (time_ms),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  // filters, peak logic and result
  sdpq_back #(
    .FILTER_FRAC_BITS (FILTER_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .step      (step)
  );

endmodule

[rtl/sdpq_front.sv]
// input acceptance, seed tagging and two-entry sample queue
`timescale 1ns / 1ps
`include "step_detector_peak_qualifier_assert.svh"

module sdpq_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         accel_magnitude,
  input  logic [31:0]         time_ms,
  output logic                q_valid,
  output sdpq_pkg::item_t     q_item,
  input  logic                q_pop
);

  sdpq_pkg::item_t                 entries [sdpq_pkg::QDEPTH];
  logic [sdpq_pkg::QPTR_W-1:0]     rd_ptr;
  logic [sdpq_pkg::QPTR_W-1:0]     wr_ptr;
  logic [sdpq_pkg::QCNT_W-1:0]     cnt;
  logic                            primed;
  logic                            push;
  logic                            pop;

  // handshake
  assign in_stall = (cnt == sdpq_pkg::QCNT_W'(sdpq_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (cnt != '0);
  assign q_item   = entries[rd_ptr];

  // queue storage, first sample after reset tagged as seed
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{accel_magnitude: accel_magnitude,
                           time_ms: time_ms,
                           seed: !primed};
    end
  end

  // pointers, fill count, primed flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      cnt    <= '0;
      primed <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
        primed <= 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  // checks
  `SDPQ_ASSERT(a_cnt_bound, clk, rst, cnt <= sdpq_pkg::QCNT_W'(sdpq_pkg::QDEPTH))
  `SDPQ_ASSERT(a_pop_nonempty, clk, rst, q_pop |-> cnt != '0)
  `SDPQ_ASSERT(a_primed_sticks, clk, rst, primed |=> primed)
  `SDPQ_CHECK(a_reset_empty, clk, rst |=> (cnt == '0 && !primed))

endmodule

[rtl/sdpq_back.sv]
// filter sequencer, peak qualification and result register
`timescale 1ns / 1ps
`include "step_detector_peak_qualifier_assert.svh"

module sdpq_back #(
  parameter int unsigned FILTER_FRAC_BITS = 28
) (
  input  logic             clk,
  input  logic             rst,
  input  sdpq_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  sdpq_pkg::item_t  q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             step
);

  localparam int unsigned LW = FILTER_FRAC_BITS + 4;
  localparam int unsigned DW = LW + 1;
  localparam int unsigned PW = LW + 16;
  localparam int unsigned S  = FILTER_FRAC_BITS - sdpq_pkg::SAMPLE_FRAC_BITS;
  localparam logic [LW-1:0] ONE = LW'(1) << FILTER_FRAC_BITS;

  typedef enum logic [2:0] {
    S_LP_MUL,
    S_LP_UPD,
    S_GR_MUL,
    S_GR_UPD,
    S_DECIDE
  } state_t;

  state_t                state;
  logic [LW-1:0]         lp;
  logic [LW-1:0]         gr;
  logic [PW-1:0]         prod;
  logic                  neg;
  logic                  in_peak;
  logic signed [DW-1:0]  peak_max;
  logic [31:0]           peak_start;
  logic [31:0]           last_step;

  logic [LW-1:0]         x;
  logic [LW-1:0]         mul_tgt;
  logic [LW-1:0]         lvl_sel;
  logic [15:0]           alpha_sel;
  logic signed [DW-1:0]  diff;
  logic [LW-1:0]         mag;
  logic [LW-1:0]         floor_q;
  logic [LW-1:0]         ceil_q;
  logic [LW-1:0]         lvl_next;

  logic signed [DW-1:0]  dyn;
  logic signed [DW-1:0]  enter_s;
  logic signed [DW-1:0]  exit_s;
  logic signed [DW-1:0]  level_s;
  logic signed [DW-1:0]  peak_max_next;
  logic [31:0]           width_ms;
  logic [31:0]           gap_ms;
  logic                  closing;
  logic                  qualifies;
  logic                  dec_fire;

  // sample in filter format
  assign x = LW'(q_item.accel_magnitude) << S;

  // shared multiply operands: low-pass first, then gravity
  always_comb begin
    if (state == S_LP_MUL || state == S_LP_UPD) begin
      lvl_sel   = lp;
      mul_tgt   = x;
      alpha_sel = cfg.low_pass_alpha;
    end else begin
      lvl_sel   = gr;
      mul_tgt   = lp;
      alpha_sel = cfg.gravity_alpha;
    end
  end

  // difference magnitude into the multiplier
  assign diff = $signed({1'b0, mul_tgt}) - $signed({1'b0, lvl_sel});
  assign mag  = diff[DW-1] ? LW'(-diff) : diff[LW-1:0];

  // floor step up, ceiling step down
  assign floor_q  = prod[PW-1:16];
  assign ceil_q   = floor_q + LW'(|prod[15:0]);
  assign lvl_next = neg ? (lvl_sel - ceil_q) : (lvl_sel + floor_q);

  // dynamic value and scaled thresholds
  assign dyn     = $signed({1'b0, lp}) - $signed({1'b0, gr});
  assign enter_s = DW'($signed(cfg.enter_thresh)) <<< S;
  assign exit_s  = DW'($signed(cfg.exit_thresh)) <<< S;
  assign level_s = DW'($signed(cfg.min_peak_level)) <<< S;

  // peak qualification
  assign peak_max_next = (dyn > peak_max) ? dyn : peak_max;
  assign width_ms      = q_item.time_ms - peak_start;
  assign gap_ms        = q_item.time_ms - last_step;
  assign closing       = dyn < exit_s;
  assign qualifies     = (peak_max_next >= level_s)
                      && (width_ms >= 32'(cfg.min_peak_width))
                      && (width_ms <= 32'(cfg.max_peak_width))
                      && ((last_step == '0) || (gap_ms >= 32'(cfg.min_step_gap)));

  assign dec_fire = (state == S_DECIDE) && !(out_valid && out_stall);
  assign q_pop    = dec_fire;

  // sequencer, filter state, peak state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LP_MUL;
      lp         <= ONE;
      gr         <= ONE;
      in_peak    <= 1'b0;
      peak_max   <= '0;
      peak_start <= '0;
      last_step  <= '0;
      out_valid  <= 1'b0;
      step       <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !dec_fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LP_MUL: begin
          if (q_valid) begin
            if (q_item.seed) begin
              lp    <= x;
              gr    <= x;
              state <= S_DECIDE;
            end else begin
              prod  <= PW'(mag) * PW'(alpha_sel);
              neg   <= diff[DW-1];
              state <= S_LP_UPD;
            end
          end
        end
        S_LP_UPD: begin
          lp    <= lvl_next;
          state <= S_GR_MUL;
        end
        S_GR_MUL: begin
          prod  <= PW'(mag) * PW'(alpha_sel);
          neg   <= diff[DW-1];
          state <= S_GR_UPD;
        end
        S_GR_UPD: begin
          gr    <= lvl_next;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (dec_fire) begin
            out_valid <= 1'b1;
            step      <= !q_item.seed && in_peak && closing && qualifies;
            state     <= S_LP_MUL;
            if (!q_item.seed) begin
              if (!in_peak) begin
                if (dyn > enter_s) begin
                  in_peak    <= 1'b1;
                  peak_max   <= dyn;
                  peak_start <= q_item.time_ms;
                end
              end else if (closing) begin
                if (qualifies) begin
                  last_step <= q_item.time_ms;
                end
                in_peak  <= 1'b0;
                peak_max <= '0;
              end else if (width_ms > 32'(cfg.max_peak_width)) begin
                in_peak  <= 1'b0;
                peak_max <= '0;
              end else begin
                peak_max <= peak_max_next;
              end
            end
          end
        end
        default: state <= S_LP_MUL;
      endcase
    end
  end

  // checks
  `SDPQ_ASSERT(a_head_held, clk, rst, (state != S_LP_MUL) |-> q_valid)
  `SDPQ_ASSERT(a_result_out, clk, rst, dec_fire |=> out_valid)
  `SDPQ_ASSERT(a_seed_no_step, clk, rst, (dec_fire && q_item.seed) |=> !step)
  `SDPQ_ASSERT(a_idle_peak_clear, clk, rst, !in_peak |-> peak_max == '0)

endmodule

[test/step_detector_peak_qualifier_test.sv]
// self-checking testbench for the step detector: walk-like streams and register settings
`timescale 1ns / 1ps

module step_detector_peak_qualifier_test;

  localparam int unsigned FRAC = 28;
  localparam int unsigned SCALE = FRAC - sdpq_pkg::SAMPLE_FRAC_BITS;
  localparam int unsigned LATENCY = 6;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam longint TIMEOUT_NS = 10_000_000;

  typedef struct {
    logic [15:0] mag;
    logic [31:0] t;
  } sample_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  // block ports
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [15:0]                    accel_magnitude = '0;
  logic [31:0]                    time_ms = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           step;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [sdpq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]                    cfg_data = '0;

  step_detector_peak_qualifier #(
    .FILTER_FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .accel_magnitude(accel_magnitude),
    .time_ms(time_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .step(step),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor copy of the registers and detector state
  sdpq_pkg::cfg_t model_cfg;
  bit          seeded = 1'b0;
  longint      lp_level = longint'(1) << FRAC;
  longint      grav_level = longint'(1) << FRAC;
  bit          peak_open = 1'b0;
  longint      peak_max = 0;
  logic [31:0] peak_t0 = '0;
  logic [31:0] last_step_t = '0;

  // stimulus and scoreboard bookkeeping
  sample_t     pending_samples[$];
  bit          step_expected[$];
  int unsigned samples_queued = 0;
  int unsigned samples_taken = 0;
  int unsigned results_seen = 0;
  int unsigned steps_predicted = 0;
  int unsigned settings_used = 1;
  int unsigned failures = 0;
  logic [31:0] walk_ms = '0;

  // sender and receiver idling state
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned stretch_in = 1;
  int unsigned stretch_out = 1;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;
  sample_t     next_sample;
  bit          got_step;
  bit          want_step;

  initial model_cfg = '{sdpq_pkg::RST_LOW_PASS_ALPHA, sdpq_pkg::RST_GRAVITY_ALPHA,
                        sdpq_pkg::RST_ENTER_THRESH, sdpq_pkg::RST_EXIT_THRESH,
                        sdpq_pkg::RST_MIN_PEAK_LEVEL, sdpq_pkg::RST_MIN_PEAK_WIDTH,
                        sdpq_pkg::RST_MAX_PEAK_WIDTH, sdpq_pkg::RST_MIN_STEP_GAP};

  // exponential filter step, product floored by the arithmetic shift
  function automatic longint ema(input longint level, input longint target,
                                 input logic [15:0] alpha);
    return level + (((target - level) * longint'(alpha)) >>> 16);
  endfunction

  // signed q4.12 register value in filter units
  function automatic longint to_level(input logic [15:0] th);
    return longint'($signed(th)) * (longint'(1) << SCALE);
  endfunction

  // idle length: mostly short, a few long, none in a calm stretch
  function automatic int unsigned idle_len(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // register write as the block sees it
  function automatic void apply_reg(input logic [sdpq_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [15:0] val);
    case (idx)
      sdpq_pkg::REG_LOW_PASS_ALPHA: model_cfg.low_pass_alpha = val;
      sdpq_pkg::REG_GRAVITY_ALPHA:  model_cfg.gravity_alpha = val;
      sdpq_pkg::REG_ENTER_THRESH:   model_cfg.enter_thresh = val;
      sdpq_pkg::REG_EXIT_THRESH:    model_cfg.exit_thresh = val;
      sdpq_pkg::REG_MIN_PEAK_LEVEL: model_cfg.min_peak_level = val;
      sdpq_pkg::REG_MIN_PEAK_WIDTH: model_cfg.min_peak_width = val;
      sdpq_pkg::REG_MAX_PEAK_WIDTH: model_cfg.max_peak_width = val;
      sdpq_pkg::REG_MIN_STEP_GAP:   model_cfg.min_step_gap = val;
      default: ;
    endcase
  endfunction

  // filters, peak tracking and step qualification for one sample
  function automatic bit compute_step(input logic [15:0] mag, input logic [31:0] t);
    longint      x;
    longint      dyn;
    logic [31:0] width;
    logic [31:0] gap;
    bit          hit;
    x = longint'(mag) << SCALE;
    hit = 1'b0;
    if (!seeded) begin
      seeded = 1'b1;
      lp_level = x;
      grav_level = x;
      return 1'b0;
    end
    lp_level = ema(lp_level, x, model_cfg.low_pass_alpha);
    grav_level = ema(grav_level, lp_level, model_cfg.gravity_alpha);
    dyn = lp_level - grav_level;
    if (!peak_open) begin
      if (dyn > to_level(model_cfg.enter_thresh)) begin
        peak_open = 1'b1;
        peak_max = dyn;
        peak_t0 = t;
      end
      return 1'b0;
    end
    if (dyn > peak_max) peak_max = dyn;
    width = t - peak_t0;
    if (dyn < to_level(model_cfg.exit_thresh)) begin
      gap = t - last_step_t;
      if (peak_max >= to_level(model_cfg.min_peak_level) &&
          width >= 32'(model_cfg.min_peak_width) &&
          width <= 32'(model_cfg.max_peak_width) &&
          (last_step_t == 0 || gap >= 32'(model_cfg.min_step_gap))) begin
        hit = 1'b1;
        last_step_t = t;
      end
      peak_open = 1'b0;
      peak_max = 0;
    end else if (width > 32'(model_cfg.max_peak_width)) begin
      peak_open = 1'b0;
      peak_max = 0;
    end
    return hit;
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        got_step = compute_step(accel_magnitude, time_ms);
        step_expected.push_back(got_step);
        if (got_step) steps_predicted++;
        samples_taken++;
        gap_left = idle_len(calm_in);
        if (--stretch_in == 0) begin
          stretch_in = $urandom_range(10, 60);
          calm_in = ($urandom_range(0, 3) == 0);
        end
      end
      if (!in_valid || !in_stall) begin
        if (gap_left == 0 && pending_samples.size() > 0) begin
          next_sample = pending_samples.pop_front();
          in_valid <= 1'b1;
          accel_magnitude <= next_sample.mag;
          time_ms <= next_sample.t;
        end else begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (step_expected.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: step transaction with none expected, step=%0b", $time, step);
        end else begin
          want_step = step_expected.pop_front();
          if (step !== want_step) begin
            failures++;
            if (failures <= 10)
              $display("%0t: result %0d step expected %0b got %0b",
                       $time, results_seen, want_step, step);
          end
        end
        // long hold-off lets the queue fill and back up the input
        if (results_seen == 200 || results_seen == 700) hold_left = HOLD_CYCLES;
        stall_left = idle_len(calm_out);
        if (--stretch_out == 0) begin
          stretch_out = $urandom_range(10, 60);
          calm_out = ($urandom_range(0, 3) == 0);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_sample(input logic [15:0] mag, input logic [31:0] t);
    sample_t s;
    s.mag = mag;
    s.t = t;
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  // walking pattern: triangle wave around a baseline with a little jitter
  task automatic add_walk(input int n, input int dt);
    int base;
    int amp;
    int period;
    int off;
    int ph;
    int tri_pos;
    int val;
    base = int'($urandom_range(3000, 6000));
    amp = int'($urandom_range(200, 7000));
    period = int'($urandom_range(250, 1500));
    off = int'($urandom_range(0, period - 1));
    for (int k = 0; k < n; k++) begin
      ph = (k * dt + off) % period;
      tri_pos = (ph < period / 2) ? ph : period - ph;
      val = base - amp / 2 + (amp * 2 * tri_pos) / period + int'($urandom_range(0, 120)) - 60;
      if (val < 0) val = 0;
      if (val > 65535) val = 65535;
      push_sample(val[15:0], walk_ms);
      walk_ms += dt;
    end
  endtask

  // mostly walks, some noise, some broken or wrapping time runs
  task automatic fill_random(input int n);
    int unsigned start;
    int unsigned r;
    int dt;
    start = samples_queued;
    while (samples_queued - start < n) begin
      r = $urandom_range(0, 19);
      dt = int'($urandom_range(5, 50));
      if (r < 13) begin
        add_walk(int'($urandom_range(15, 50)), dt);
      end else if (r < 16) begin
        repeat ($urandom_range(1, 5))
          push_sample(16'($urandom_range(0, 65535)),
                      $urandom_range(0, 1) ? $urandom : walk_ms + $urandom_range(0, 2000));
      end else if (r < 18) begin
        walk_ms = 32'hFFFF_FFFF - $urandom_range(0, 800);
        add_walk(int'($urandom_range(20, 50)), dt);
      end else begin
        // lands a sample exactly on time zero, except when the run ends first
        walk_ms = 32'(-(dt * int'($urandom_range(1, 20))));
        add_walk(int'($urandom_range(20, 50)), dt);
      end
    end
  endtask

  task automatic wait_idle();
    while (samples_taken != samples_queued || step_expected.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sdpq_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  // new register setting once the block is idle, then a random batch
  task automatic run_phase(input sdpq_pkg::cfg_t regs, input int n);
    wait_idle();
    write_reg(sdpq_pkg::REG_LOW_PASS_ALPHA, regs.low_pass_alpha);
    write_reg(sdpq_pkg::REG_GRAVITY_ALPHA, regs.gravity_alpha);
    write_reg(sdpq_pkg::REG_ENTER_THRESH, regs.enter_thresh);
    write_reg(sdpq_pkg::REG_EXIT_THRESH, regs.exit_thresh);
    write_reg(sdpq_pkg::REG_MIN_PEAK_LEVEL, regs.min_peak_level);
    write_reg(sdpq_pkg::REG_MIN_PEAK_WIDTH, regs.min_peak_width);
    write_reg(sdpq_pkg::REG_MAX_PEAK_WIDTH, regs.max_peak_width);
    write_reg(sdpq_pkg::REG_MIN_STEP_GAP, regs.min_step_gap);
    // unmapped index must leave every register alone
    write_reg(sdpq_pkg::CFG_IDX_W'($urandom_range(8, 15)), 16'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
    fill_random(n);
  endtask

  // test sequence
  initial begin
    sdpq_pkg::cfg_t regs;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: seed, a pulse across the time wrap, field extremes
    for (int k = 0; k < 18; k++)
      push_sample((k >= 4 && k < 10) ? 16'd8192 : 16'd4096, 32'hFFFF_FF00 + 32'(16 * k));
    push_sample(16'hFFFF, 32'd400);
    push_sample(16'hFFFF, 32'd420);
    push_sample(16'h0000, 32'd440);
    push_sample(16'h0000, 32'd460);
    push_sample(16'd4096, 32'hFFFF_FFFF);
    push_sample(16'd4096, 32'h0000_0000);

    run_phase('{sdpq_pkg::RST_LOW_PASS_ALPHA, sdpq_pkg::RST_GRAVITY_ALPHA,
                sdpq_pkg::RST_ENTER_THRESH, sdpq_pkg::RST_EXIT_THRESH,
                sdpq_pkg::RST_MIN_PEAK_LEVEL, sdpq_pkg::RST_MIN_PEAK_WIDTH,
                sdpq_pkg::RST_MAX_PEAK_WIDTH, sdpq_pkg::RST_MIN_STEP_GAP}, 160);
    // everything qualifies: peaks open and close on alternate samples
    run_phase('{16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                16'h0000}, 120);
    // nothing qualifies, filters frozen or instant
    run_phase('{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000,
                16'hFFFF}, 80);
    // plausible settings around walking cadence
    repeat (4) begin
      regs.low_pass_alpha = 16'($urandom_range(3000, 30000));
      regs.gravity_alpha = 16'($urandom_range(200, 4000));
      regs.enter_thresh = 16'($urandom_range(300, 2000));
      regs.exit_thresh = 16'($urandom_range(0, regs.enter_thresh));
      regs.min_peak_level = 16'($urandom_range(regs.enter_thresh, 3000));
      regs.min_peak_width = 16'($urandom_range(0, 100));
      regs.max_peak_width = 16'($urandom_range(200, 800));
      regs.min_step_gap = 16'($urandom_range(100, 500));
      run_phase(regs, 140);
    end
    // arbitrary values, thresholds possibly in the wrong order
    regs = sdpq_pkg::cfg_t'({$urandom, $urandom, $urandom, $urandom});
    run_phase(regs, 100);

    wait_idle();
    $display("ran %0d samples under %0d register settings", samples_taken, settings_used);
    $display("%0d results checked, %0d of them steps; %0d failures",
             results_seen, steps_predicted, failures);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", step_expected.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
